FILE: design/sorted_key_table_16_core_macros.svh
// Assertion helpers for the sorted key table RTL.
`ifndef SORTED_KEY_TABLE_16_CORE_MACROS_SVH
`define SORTED_KEY_TABLE_16_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define SKT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted key table check failed");
// Next-cycle implication, disabled while reset is held.
`define SKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key table check failed");
`else
`define SKT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SKT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/skt16_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skt16_pkg;

    localparam int ENTRIES     = 16;
    localparam int VALUE_BITS  = 32;
    localparam int MAX_RESULTS = 16;
    localparam int KEY_W       = 8;
    localparam int OP_W        = 3;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CNT_W       = $clog2(ENTRIES + 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 3'd0,
        OP_INSERT = 3'd1,
        OP_CHANGE = 3'd2,
        OP_REMOVE = 3'd3,
        OP_RANGE  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_VALUE,
        CELL_LEFT,
        CELL_RIGHT
    } t_cell_cmd;

    typedef struct packed {
        logic gt;
        logic eq;
        logic eq_end;
    } t_cell_flags;

    typedef enum logic {
        ST_IDLE,
        ST_RANGE
    } t_state;

    typedef struct packed {
        t_status               status;
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] value;
        logic [CNT_W-1:0]      count;
        logic                  last;
    } t_rsp_data;

endpackage

`default_nettype wire

FILE: design/skt16_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface skt16_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [skt16_pkg::OP_W-1:0]            operation;
    logic [skt16_pkg::KEY_W-1:0]           key;
    logic [skt16_pkg::KEY_W-1:0]           end_key;
    logic [skt16_pkg::VALUE_BITS-1:0]      child_value;

    modport source (output valid, operation, key, end_key, child_value, input ready);
    modport sink   (input valid, operation, key, end_key, child_value, output ready);
endinterface

`default_nettype wire

FILE: design/skt16_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface skt16_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            status;
    logic [skt16_pkg::KEY_W-1:0]           out_key;
    logic [skt16_pkg::VALUE_BITS-1:0]      out_value;
    logic [skt16_pkg::CNT_W-1:0]           entry_count;
    logic                                  last;

    modport source (output valid, status, out_key, out_value, entry_count, last, input ready);
    modport sink   (input valid, status, out_key, out_value, entry_count, last, output ready);
endinterface

`default_nettype wire

FILE: design/skt16_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module skt16_cell (
    input  wire logic                                i_clk,
    input  wire skt16_pkg::t_cell_cmd                i_cmd,
    input  wire logic                                i_used,
    input  wire logic [skt16_pkg::KEY_W-1:0]         i_key,
    input  wire logic [skt16_pkg::KEY_W-1:0]         i_end_key,
    input  wire logic [skt16_pkg::VALUE_BITS-1:0]    i_value,
    input  wire logic [skt16_pkg::KEY_W-1:0]         i_left_key,
    input  wire logic [skt16_pkg::VALUE_BITS-1:0]    i_left_value,
    input  wire logic [skt16_pkg::KEY_W-1:0]         i_right_key,
    input  wire logic [skt16_pkg::VALUE_BITS-1:0]    i_right_value,
    output logic [skt16_pkg::KEY_W-1:0]              o_key,
    output logic [skt16_pkg::VALUE_BITS-1:0]         o_value,
    output skt16_pkg::t_cell_flags                   o_flags
);

    logic [skt16_pkg::KEY_W-1:0]      r_key;
    logic [skt16_pkg::VALUE_BITS-1:0] r_value;
    logic [skt16_pkg::KEY_W-1:0]      n_key;
    logic [skt16_pkg::VALUE_BITS-1:0] n_value;

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        unique case (i_cmd)
            skt16_pkg::CELL_HOLD: begin
            end
            skt16_pkg::CELL_LOAD: begin
                n_key   = i_key;
                n_value = i_value;
            end
            skt16_pkg::CELL_VALUE: begin
                n_value = i_value;
            end
            skt16_pkg::CELL_LEFT: begin
                n_key   = i_left_key;
                n_value = i_left_value;
            end
            skt16_pkg::CELL_RIGHT: begin
                n_key   = i_right_key;
                n_value = i_right_value;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    // Compares only count for slots that hold a live entry.
    assign o_flags.gt     = i_used && (r_key > i_key);
    assign o_flags.eq     = i_used && (r_key == i_key);
    assign o_flags.eq_end = i_used && (r_key == i_end_key);
    assign o_key          = r_key;
    assign o_value        = r_value;

endmodule

`default_nettype wire

FILE: design/sorted_key_table_16_core.sv
// Sorted table of up to 16 byte keys, each with a 32-bit value, kept in ascending
// key order in a chain of cells. Every cell compares its key against the request in
// parallel, and insert or remove shift the chain by one place toward a neighbor.
// Lookup, insert, change and remove each give one response; a range read of n
// entries gives one response per entry from the start key's slot to the end key's
// slot (first slot or last entry when a key is absent); after the accept it makes
// one load per entry, each waiting until the output register is free, and no new
// request is taken until the last of them is loaded. An empty range gives one
// not-found response. Insert into a full table reports status full; change or
// remove of an absent key reports not found and leaves the table unchanged. A
// request is taken only when the output register is empty or its response leaves
// in that same cycle, so a stalled response holds off the next request.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_key_table_16_core_macros.svh"

module sorted_key_table_16_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    skt16_req_if.sink   i_req,
    skt16_rsp_if.source o_rsp
);

    localparam int ENTRIES = skt16_pkg::ENTRIES;
    localparam int IDX_W   = skt16_pkg::IDX_W;
    localparam int CNT_W   = skt16_pkg::CNT_W;
    localparam int KEY_W   = skt16_pkg::KEY_W;
    localparam int VB      = skt16_pkg::VALUE_BITS;

    function automatic logic [IDX_W-1:0] onehot_index(input logic [ENTRIES-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (v[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

    skt16_pkg::t_state      r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_final, n_final;
    logic                   r_out_valid, n_out_valid;
    skt16_pkg::t_rsp_data   r_out, n_out;

    logic [KEY_W-1:0]       w_key      [ENTRIES];
    logic [VB-1:0]          w_value    [ENTRIES];
    logic [KEY_W-1:0]       w_left_key [ENTRIES];
    logic [VB-1:0]          w_left_val [ENTRIES];
    logic [KEY_W-1:0]       w_right_key[ENTRIES];
    logic [VB-1:0]          w_right_val[ENTRIES];
    skt16_pkg::t_cell_flags w_flags    [ENTRIES];
    skt16_pkg::t_cell_cmd   w_cmd      [ENTRIES];

    logic [ENTRIES-1:0]     w_used, w_gt, w_eq, w_eq_end;
    logic [ENTRIES-1:0]     w_first_gt, w_first_eq, w_first_end, w_from_hit;
    logic                   w_any_gt, w_hit, w_hit_end;
    logic [VB-1:0]          w_hit_value;
    logic [IDX_W-1:0]       w_first_idx, w_final_idx, w_span;
    logic                   w_accept, w_out_free, w_full, w_range_empty;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_left_key[g] = '0;
                assign w_left_val[g] = '0;
            end else begin : g_mid
                assign w_left_key[g] = w_key[g-1];
                assign w_left_val[g] = w_value[g-1];
            end
            if (g == ENTRIES - 1) begin : g_tail
                assign w_right_key[g] = '0;
                assign w_right_val[g] = '0;
            end else begin : g_body
                assign w_right_key[g] = w_key[g+1];
                assign w_right_val[g] = w_value[g+1];
            end

            skt16_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd[g]),
                .i_used       (w_used[g]),
                .i_key        (i_req.key),
                .i_end_key    (i_req.end_key),
                .i_value      (i_req.child_value),
                .i_left_key   (w_left_key[g]),
                .i_left_value (w_left_val[g]),
                .i_right_key  (w_right_key[g]),
                .i_right_value(w_right_val[g]),
                .o_key        (w_key[g]),
                .o_value      (w_value[g]),
                .o_flags      (w_flags[g])
            );
        end
    endgenerate

    // Keys are sorted, so each flag vector is one contiguous run of ones.
    always_comb begin
        w_hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_used[i]   = CNT_W'(i) < r_count;
            w_gt[i]     = w_flags[i].gt;
            w_eq[i]     = w_flags[i].eq;
            w_eq_end[i] = w_flags[i].eq_end;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (i == 0) begin
                w_first_gt[i]  = w_gt[i];
                w_first_eq[i]  = w_eq[i];
                w_first_end[i] = w_eq_end[i];
                w_from_hit[i]  = w_eq[i];
            end else begin
                w_first_gt[i]  = w_gt[i] && !w_gt[i-1];
                w_first_eq[i]  = w_eq[i] && !w_eq[i-1];
                w_first_end[i] = w_eq_end[i] && !w_eq_end[i-1];
                w_from_hit[i]  = w_eq[i] || w_from_hit[i-1];
            end
            if (w_first_eq[i]) begin
                w_hit_value = w_hit_value | w_value[i];
            end
        end
        w_any_gt  = |w_gt;
        w_hit     = |w_eq;
        w_hit_end = |w_eq_end;
        w_full    = r_count >= CNT_W'(ENTRIES);

        w_first_idx = w_hit ? onehot_index(w_first_eq) : '0;
        w_final_idx = w_hit_end ? onehot_index(w_first_end) : IDX_W'(r_count - CNT_W'(1));
        w_range_empty = (r_count == '0) || (w_final_idx < w_first_idx);
        w_span = w_final_idx - w_first_idx;
        // Trim the range to the response limit.
        if (int'(w_span) >= skt16_pkg::MAX_RESULTS) begin
            w_final_idx = w_first_idx + IDX_W'(skt16_pkg::MAX_RESULTS - 1);
        end
    end

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == skt16_pkg::ST_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_final     = r_final;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        for (int i = 0; i < ENTRIES; i++) begin
            w_cmd[i] = skt16_pkg::CELL_HOLD;
        end

        if (w_accept) begin
            n_out_valid  = 1'b1;
            n_out.status = skt16_pkg::STAT_MISS;
            n_out.key    = i_req.key;
            n_out.value  = '0;
            n_out.last   = 1'b1;
            unique case (i_req.operation)
                skt16_pkg::OP_LOOKUP: begin
                    if (w_hit) begin
                        n_out.status = skt16_pkg::STAT_OK;
                        n_out.value  = w_hit_value;
                    end
                end
                skt16_pkg::OP_INSERT: begin
                    if (w_full) begin
                        n_out.status = skt16_pkg::STAT_FULL;
                    end else begin
                        // Open a gap before the first greater key and drop the new entry in.
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (i > 0 && w_gt[i-1]) begin
                                w_cmd[i] = skt16_pkg::CELL_LEFT;
                            end else if (w_first_gt[i] ||
                                         (!w_any_gt && CNT_W'(i) == r_count)) begin
                                w_cmd[i] = skt16_pkg::CELL_LOAD;
                            end
                        end
                        n_count      = r_count + CNT_W'(1);
                        n_out.status = skt16_pkg::STAT_OK;
                    end
                end
                skt16_pkg::OP_CHANGE: begin
                    if (w_hit) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (w_first_eq[i]) begin
                                w_cmd[i] = skt16_pkg::CELL_VALUE;
                            end
                        end
                        n_out.status = skt16_pkg::STAT_OK;
                    end
                end
                skt16_pkg::OP_REMOVE: begin
                    if (w_hit) begin
                        // Close the gap: every live entry past the match moves down one.
                        for (int i = 0; i < ENTRIES - 1; i++) begin
                            if (w_from_hit[i] && w_used[i+1]) begin
                                w_cmd[i] = skt16_pkg::CELL_RIGHT;
                            end
                        end
                        n_count      = r_count - CNT_W'(1);
                        n_out.status = skt16_pkg::STAT_OK;
                    end
                end
                skt16_pkg::OP_RANGE: begin
                    if (!w_range_empty) begin
                        n_out_valid = r_out_valid && !o_rsp.ready;
                        n_state     = skt16_pkg::ST_RANGE;
                        n_idx       = w_first_idx;
                        n_final     = w_final_idx;
                    end
                end
                default: begin
                end
            endcase
            n_out.count = n_count;
        end else if (r_state == skt16_pkg::ST_RANGE && w_out_free) begin
            n_out_valid  = 1'b1;
            n_out.status = skt16_pkg::STAT_OK;
            n_out.key    = w_key[r_idx];
            n_out.value  = w_value[r_idx];
            n_out.count  = r_count;
            n_out.last   = (r_idx == r_final);
            n_idx        = r_idx + IDX_W'(1);
            if (r_idx == r_final) begin
                n_state = skt16_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skt16_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_final <= n_final;
        r_out   <= n_out;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.out_key     = r_out.key;
    assign o_rsp.out_value   = r_out.value;
    assign o_rsp.entry_count = r_out.count;
    assign o_rsp.last        = r_out.last;

    `SKT_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_accept && i_req.operation == skt16_pkg::OP_INSERT && !w_full, r_count == $past(r_count) + CNT_W'(1))
    `SKT_ASSERT_NEXT(a_remove_shrinks, i_clk, i_rst_n, w_accept && i_req.operation == skt16_pkg::OP_REMOVE && w_hit, r_count == $past(r_count) - CNT_W'(1))
    `SKT_ASSERT_IMPL(a_range_bounds, i_clk, i_rst_n, r_state == skt16_pkg::ST_RANGE, r_idx <= r_final && CNT_W'(r_final) < r_count)
    `SKT_ASSERT_NEXT(a_range_ends, i_clk, i_rst_n, r_state == skt16_pkg::ST_RANGE && w_out_free && r_idx == r_final, r_state == skt16_pkg::ST_IDLE && o_rsp.valid && o_rsp.last)

endmodule

`default_nettype wire
